@@ hdl/dshot_frame_codec_top_macros.svh @@
// assertion helpers used by the codec back end
`ifndef DSHOT_FRAME_CODEC_TOP_MACROS_SVH
`define DSHOT_FRAME_CODEC_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define DFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dshot codec check failed");

// next-cycle implication, disabled while reset is active
`define DFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dshot codec check failed");

`endif

@@ hdl/dfc_pkg.sv @@
`default_nettype none
package dfc_pkg;

	// frame geometry
	localparam int FRAME_BITS      = 16;
	localparam int GAP_WORDS_DEF   = 2;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int CNT_W           = $clog2(FRAME_BITS);

	// value clamp
	localparam logic [10:0] VALUE_MAX = 11'h7ff;

	// config port
	localparam int ADDR_W = 4;
	localparam logic [15:0] ONE_WIDTH_RST  = 16'd0;
	localparam logic [15:0] ZERO_WIDTH_RST = 16'd0;
	localparam logic [7:0]  TOL_RST        = 8'd15;

	typedef enum logic [1:0] {
		REG_ONE_WIDTH  = 2'd0,
		REG_ZERO_WIDTH = 2'd1,
		REG_TOLERANCE  = 2'd2
	} reg_idx_t;

	// input opcodes and output kinds
	localparam logic OP_ENCODE   = 1'b0;
	localparam logic OP_DECODE   = 1'b1;
	localparam logic KIND_WIDTH  = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	typedef struct packed {
		logic [15:0] one_width;
		logic [15:0] zero_width;
		logic [7:0]  tolerance;
	} cfg_t;

	// one queued job: an encoded frame or a collected received frame
	typedef struct packed {
		logic        is_dec;
		logic [15:0] frame;
		logic        bad;
	} job_t;

	// xor of the three nibbles of a 12-bit word
	function automatic logic [3:0] crc_nibble(input logic [11:0] w12);
		crc_nibble = w12[3:0] ^ w12[7:4] ^ w12[11:8];
	endfunction

	// open window test in 18-bit signed arithmetic, no wrap possible
	function automatic logic in_window(input logic [15:0] w, input logic [15:0] nom,
			input logic [7:0] tol);
		logic signed [17:0] ws;
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		ws = signed'({2'b00, w});
		lo = signed'({2'b00, nom}) - signed'({10'd0, tol});
		hi = signed'({2'b00, nom}) + signed'({10'd0, tol});
		in_window = (ws > lo) && (ws < hi);
	endfunction

endpackage
`default_nettype wire

@@ hdl/dfc_in_if.sv @@
`default_nettype none
interface dfc_in_if;
	logic        valid;
	logic        ready;
	logic [0:0]  opcode;
	logic [15:0] command_value;
	logic [0:0]  telemetry_request;
	logic [15:0] captured_width;

	modport source (output valid, opcode, command_value, telemetry_request, captured_width,
		input ready);
	modport sink (input valid, opcode, command_value, telemetry_request, captured_width,
		output ready);
endinterface
`default_nettype wire

@@ hdl/dfc_out_if.sv @@
`default_nettype none
interface dfc_out_if;
	logic        valid;
	logic        ready;
	logic [0:0]  kind;
	logic [15:0] width_word;
	logic [10:0] decoded_value;
	logic [0:0]  decode_ok;
	logic [0:0]  last;

	modport source (output valid, kind, width_word, decoded_value, decode_ok, last,
		input ready);
	modport sink (input valid, kind, width_word, decoded_value, decode_ok, last,
		output ready);
endinterface
`default_nettype wire

@@ hdl/dfc_front.sv @@
`default_nettype none
module dfc_front
	import dfc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	dfc_in_if.sink    item_in,
	input  wire logic q_full,
	output logic      push,
	output job_t      push_job
);

	logic [CNT_W-1:0] bit_count_q;
	logic [15:0]      frame_shift_q;
	logic             frame_bad_q;

	logic             accept;
	logic             is_dec;
	logic             bit_one;
	logic             bit_bad;
	logic [15:0]      shift_nxt;
	logic             bad_nxt;
	logic             frame_done;
	logic [10:0]      value_clamped;
	logic [11:0]      word12;

	assign item_in.ready = !q_full;
	assign accept = item_in.valid && item_in.ready;
	assign is_dec = (item_in.opcode == OP_DECODE);

	// classify one captured width, one window wins over zero window
	always_comb begin
		bit_one = in_window(item_in.captured_width, cfg.one_width, cfg.tolerance);
		bit_bad = !bit_one && !in_window(item_in.captured_width, cfg.zero_width,
			cfg.tolerance);
		shift_nxt = {frame_shift_q[14:0], bit_one};
		bad_nxt = frame_bad_q || bit_bad;
		frame_done = (bit_count_q == CNT_W'(FRAME_BITS - 1));
	end

	// build the outgoing 12-bit word: clamp, telemetry bit; the checksum is appended at the push
	always_comb begin
		value_clamped = (item_in.command_value > {5'd0, VALUE_MAX}) ? VALUE_MAX :
			item_in.command_value[10:0];
		word12 = {value_clamped, item_in.telemetry_request};
	end

	// queue a job for every encode item and for each completed received frame
	always_comb begin
		push = accept && (!is_dec || frame_done);
		push_job.is_dec = is_dec;
		push_job.frame = is_dec ? shift_nxt : {word12, crc_nibble(word12)};
		push_job.bad = is_dec && bad_nxt;
	end

	// receive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
			frame_shift_q <= '0;
			frame_bad_q <= 1'b0;
		end else if (accept && is_dec) begin
			if (frame_done) begin
				bit_count_q <= '0;
				frame_shift_q <= '0;
				frame_bad_q <= 1'b0;
			end else begin
				bit_count_q <= bit_count_q + CNT_W'(1);
				frame_shift_q <= shift_nxt;
				frame_bad_q <= bad_nxt;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/dfc_queue.sv @@
`default_nettype none
module dfc_queue
	import dfc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output job_t      head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	job_t              slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full = (count_q == CNT_QW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

@@ hdl/dfc_back.sv @@
`default_nettype none
module dfc_back
	import dfc_pkg::*;
#(
	parameter int GAP_WORDS = GAP_WORDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	dfc_out_if.source item_out
);

`include "dshot_frame_codec_top_macros.svh"

	localparam int TOTAL = FRAME_BITS + GAP_WORDS;
	localparam int IDX_W = $clog2(TOTAL + 1);

	logic             active_q;
	logic             job_dec_q;
	logic [15:0]      shift_q;
	logic             bad_q;
	logic [IDX_W-1:0] idx_q;

	logic             out_valid_q;
	logic             kind_q;
	logic [15:0]      width_word_q;
	logic [10:0]      decoded_value_q;
	logic             decode_ok_q;
	logic             last_q;

	logic             adv;
	logic             final_word;
	logic             burst_last;
	logic             in_frame;
	logic             dec_ok;

	assign adv = !out_valid_q || item_out.ready;
	assign burst_last = (idx_q == IDX_W'(TOTAL - 1));
	assign final_word = job_dec_q || burst_last;
	assign pop = head_valid && (!active_q || (adv && final_word));
	assign in_frame = (idx_q < IDX_W'(FRAME_BITS));
	assign dec_ok = !bad_q && (crc_nibble(shift_q[15:4]) == shift_q[3:0]);

	// job sequencing: one output word per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && active_q && final_word) begin
				active_q <= 1'b0;
			end else if (adv && active_q) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (adv) begin
				out_valid_q <= active_q;
			end
		end
	end

	// job payload and output word
	always_ff @(posedge clk) begin
		if (pop) begin
			job_dec_q <= head_job.is_dec;
			shift_q <= head_job.frame;
			bad_q <= head_job.bad;
		end else if (adv && active_q) begin
			shift_q <= {shift_q[14:0], 1'b0};
		end
		if (adv && active_q) begin
			if (job_dec_q) begin
				kind_q <= KIND_RESULT;
				width_word_q <= '0;
				decoded_value_q <= dec_ok ? shift_q[15:5] : '0;
				decode_ok_q <= dec_ok;
				last_q <= 1'b0;
			end else begin
				kind_q <= KIND_WIDTH;
				width_word_q <= !in_frame ? '0 :
					(shift_q[15] ? cfg.one_width : cfg.zero_width);
				decoded_value_q <= '0;
				decode_ok_q <= 1'b0;
				last_q <= burst_last;
			end
		end
	end

	assign item_out.valid = out_valid_q;
	assign item_out.kind = kind_q;
	assign item_out.width_word = width_word_q;
	assign item_out.decoded_value = decoded_value_q;
	assign item_out.decode_ok = decode_ok_q;
	assign item_out.last = last_q;

	// checks
	`DFC_ASSERT_NOW(a_result_not_last, clk, arst_n, out_valid_q && kind_q == KIND_RESULT,
		!last_q)
	`DFC_ASSERT_NOW(a_width_no_result, clk, arst_n, out_valid_q && kind_q == KIND_WIDTH,
		decoded_value_q == '0 && !decode_ok_q)
	`DFC_ASSERT_NEXT(a_burst_no_bubble, clk, arst_n,
		out_valid_q && kind_q == KIND_WIDTH && !last_q && item_out.ready, out_valid_q)

endmodule
`default_nettype wire

@@ hdl/dshot_frame_codec_top.sv @@
// channel    dir  handshake     payload
// item_in    in   valid/ready   opcode, command_value, telemetry_request, captured_width
// item_out   out  valid/ready   kind, width_word, decoded_value, decode_ok, last
// apb        in   psel/penable  one_width @0x0, zero_width @0x4, width_tolerance @0x8
//
// an encode item gives FRAME_BITS + GAP_WORDS words (18 by default), one per cycle while item_out is ready,
// set by the back end word sequencer; the next job starts the cycle after the last word
// a decode item is taken while the job queue is not full; every 16th width queues one frame result
// input and output stall apart through a QUEUE_DEPTH-entry job queue (two by default) and an output register
// arst_n clears receive state, queue and sequencer and loads the config reset values at once
`default_nettype none
module dshot_frame_codec_top
	import dfc_pkg::*;
#(
	parameter int GAP_WORDS   = GAP_WORDS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	dfc_in_if.sink                 item_in,
	dfc_out_if.source              item_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_width <= ONE_WIDTH_RST;
			cfg_q.zero_width <= ZERO_WIDTH_RST;
			cfg_q.tolerance <= TOL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ONE_WIDTH: cfg_q.one_width <= pwdata[15:0];
				REG_ZERO_WIDTH: cfg_q.zero_width <= pwdata[15:0];
				REG_TOLERANCE: cfg_q.tolerance <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_ONE_WIDTH: prdata = {16'd0, cfg_q.one_width};
			REG_ZERO_WIDTH: prdata = {16'd0, cfg_q.zero_width};
			REG_TOLERANCE: prdata = {24'd0, cfg_q.tolerance};
			default: prdata = '0;
		endcase
	end

	dfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item_in  (item_in),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	dfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	dfc_back #(
		.GAP_WORDS (GAP_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.item_out   (item_out)
	);

endmodule
`default_nettype wire
